FILE: sv/hta_pkg.sv
`default_nettype none

package hta_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned VALUE_W  = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INVAL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;

  localparam int unsigned FIRST_SIZE = 4;
  localparam logic [VALUE_W-1:0] MARKER = '1;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle_in;
    logic [VALUE_W-1:0]  value_in;
  } in_beat_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [VALUE_W-1:0]  value_out;
    logic                fault;
  } out_beat_t;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_H    = 2'd1,
    RD_ONE  = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_EXEC  = 3'd1,
    WR_SCAN  = 3'd2,
    WR_GROW  = 3'd3,
    WR_SWEEP = 3'd4
  } wr_sel_e;

  typedef enum logic [2:0] {
    RES_HOLD = 3'd0,
    RES_ZERO = 3'd1,
    RES_IDX  = 3'd2,
    RES_GROW = 3'd3,
    RES_EXEC = 3'd4
  } res_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_ONE  = 2'd1,
    IDX_INC  = 2'd2,
    IDX_GROW = 2'd3
  } idx_op_e;

  typedef enum logic [1:0] {
    SZ_HOLD  = 2'd0,
    SZ_CLEAR = 2'd1,
    SZ_GROW  = 2'd2
  } size_op_e;

  typedef struct packed {
    logic     cap;
    rd_sel_e  rd;
    wr_sel_e  wr;
    res_sel_e res;
    idx_op_e  idx;
    size_op_e size;
    logic     load_out;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             is_null;
    logic             live;
    logic             size_zero;
    logic             scan_hit;
    logic             idx_last;
    logic             grow_ok;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/hta_datapath.sv
`default_nettype none

module hta_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hta_pkg::in_beat_t  in_beat_i,
  input  wire hta_pkg::ctrl_t     ctrl_i,
  output hta_pkg::sts_t           sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hta_pkg::out_beat_t      out_beat_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (SW > hta_pkg::HANDLE_W) ? SW : hta_pkg::HANDLE_W;

  logic [hta_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [hta_pkg::VALUE_W-1:0] rdata_q;

  logic [hta_pkg::CMD_W-1:0]    cmd_q;
  logic [hta_pkg::HANDLE_W-1:0] h_q;
  logic [hta_pkg::VALUE_W-1:0]  v_q;

  logic [SW-1:0] size_q, size_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [SW:0]   grown;
  logic [IW-1:0] grow_n;
  logic [IW-1:0] raddr, waddr;
  logic [hta_pkg::VALUE_W-1:0] wdata;
  logic          we;

  hta_pkg::out_beat_t res_q, res_d;
  hta_pkg::out_beat_t out_q;
  logic               out_valid_q, out_valid_d;

  // Input capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      cmd_q <= in_beat_i.cmd;
      h_q   <= in_beat_i.handle_in;
      v_q   <= in_beat_i.value_in;
    end
  end

  // First growth lands at handle 1, later ones at the old size.
  assign grown  = (size_q == '0) ? (SW+1)'(hta_pkg::FIRST_SIZE) : {size_q, 1'b0};
  assign grow_n = (size_q == '0) ? IW'(1) : IW'(size_q);

  always_comb begin
    case (ctrl_i.rd)
      hta_pkg::RD_H:    raddr = IW'(h_q);
      hta_pkg::RD_ONE:  raddr = IW'(1);
      hta_pkg::RD_NEXT: raddr = idx_q + IW'(1);
      default:          raddr = idx_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    case (ctrl_i.wr)
      hta_pkg::WR_EXEC: begin
        waddr = IW'(h_q);
        if (cmd_q == hta_pkg::CMD_PUT) begin
          we = 1'b1;
        end else if (cmd_q == hta_pkg::CMD_INVAL) begin
          we    = 1'b1;
          wdata = hta_pkg::MARKER;
        end
      end
      hta_pkg::WR_SCAN: begin
        we    = (cmd_q == hta_pkg::CMD_GET);
        wdata = v_q;
      end
      hta_pkg::WR_GROW: begin
        we    = 1'b1;
        waddr = grow_n;
        wdata = v_q;
      end
      hta_pkg::WR_SWEEP: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    case (ctrl_i.idx)
      hta_pkg::IDX_ONE:  idx_d = IW'(1);
      hta_pkg::IDX_INC:  idx_d = idx_q + IW'(1);
      hta_pkg::IDX_GROW: idx_d = grow_n + IW'(1);
      default:           idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.size)
      hta_pkg::SZ_CLEAR: size_d = '0;
      hta_pkg::SZ_GROW:  size_d = grown[SW-1:0];
      default:           size_d = size_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      idx_q  <= '0;
    end else begin
      size_q <= size_d;
      idx_q  <= idx_d;
    end
  end

  always_comb begin
    res_d = res_q;
    case (ctrl_i.res)
      hta_pkg::RES_ZERO: res_d = '0;
      hta_pkg::RES_IDX: begin
        res_d            = '0;
        res_d.handle_out = hta_pkg::HANDLE_W'(idx_q);
      end
      hta_pkg::RES_GROW: begin
        res_d            = '0;
        res_d.handle_out = hta_pkg::HANDLE_W'(grow_n);
      end
      hta_pkg::RES_EXEC: begin
        res_d = '0;
        if (cmd_q == hta_pkg::CMD_PUT) begin
          res_d.value_out = rdata_q;
        end else if (cmd_q == hta_pkg::CMD_LOOKUP) begin
          res_d.value_out = (rdata_q == hta_pkg::MARKER) ? '0 : rdata_q;
        end else if (cmd_q == hta_pkg::CMD_INVAL) begin
          res_d.fault = (rdata_q == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Output register; the result of the next item may load as this beat leaves.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_comb begin
    sts_o           = '0;
    sts_o.cmd       = cmd_q;
    sts_o.is_null   = (v_q == '0) || (v_q == hta_pkg::MARKER);
    sts_o.live      = (h_q != '0) && (CW'(h_q) < CW'(size_q));
    sts_o.size_zero = (size_q == '0);
    sts_o.scan_hit  = ((cmd_q == hta_pkg::CMD_GET) && (rdata_q == '0)) ||
                      ((cmd_q == hta_pkg::CMD_FIND) && (rdata_q == v_q));
    sts_o.idx_last  = (SW'(idx_q) + SW'(1)) == size_q;
    sts_o.grow_ok   = grown <= (SW+1)'(TABLE_DEPTH);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  a_size_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q == '0) ||
    ((size_q >= SW'(hta_pkg::FIRST_SIZE)) && (size_q <= SW'(TABLE_DEPTH))))
    else $error("live size out of its legal set");

  a_no_write_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (waddr != '0) && (SW'(waddr) < size_d))
    else $error("table write outside the live slots");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting beat");

endmodule

`default_nettype wire

FILE: sv/hta_ctrl.sv
`default_nettype none

module hta_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire hta_pkg::sts_t  sts_i,
  output hta_pkg::ctrl_t      ctrl_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_GROW   = 7'b0010000,
    S_SWEEP  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.rd       = hta_pkg::RD_IDX;
    ctrl_o.wr       = hta_pkg::WR_NONE;
    ctrl_o.res      = hta_pkg::RES_HOLD;
    ctrl_o.idx      = hta_pkg::IDX_HOLD;
    ctrl_o.size     = hta_pkg::SZ_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cap = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d    = S_DONE;
        ctrl_o.res = hta_pkg::RES_ZERO;
        case (sts_i.cmd)
          hta_pkg::CMD_CLEAR: begin
            ctrl_o.size = hta_pkg::SZ_CLEAR;
          end
          hta_pkg::CMD_GET, hta_pkg::CMD_FIND: begin
            if (!sts_i.is_null) begin
              if (!sts_i.size_zero) begin
                ctrl_o.res = hta_pkg::RES_HOLD;
                ctrl_o.rd  = hta_pkg::RD_ONE;
                ctrl_o.idx = hta_pkg::IDX_ONE;
                state_d    = S_SCAN;
              end else if (sts_i.cmd == hta_pkg::CMD_GET) begin
                ctrl_o.res = hta_pkg::RES_HOLD;
                state_d    = S_GROW;
              end
            end
          end
          hta_pkg::CMD_PUT, hta_pkg::CMD_LOOKUP, hta_pkg::CMD_INVAL: begin
            if (sts_i.live) begin
              ctrl_o.res = hta_pkg::RES_HOLD;
              ctrl_o.rd  = hta_pkg::RD_H;
              state_d    = S_EXEC;
            end
          end
          default: ;
        endcase
      end
      S_EXEC: begin
        ctrl_o.res = hta_pkg::RES_EXEC;
        ctrl_o.wr  = hta_pkg::WR_EXEC;
        state_d    = S_DONE;
      end
      S_SCAN: begin
        // read data holds the slot at idx; the next slot is fetched meanwhile when the scan goes on
        if (sts_i.scan_hit) begin
          ctrl_o.res = hta_pkg::RES_IDX;
          ctrl_o.wr  = hta_pkg::WR_SCAN;
          state_d    = S_DONE;
        end else if (sts_i.idx_last) begin
          if (sts_i.cmd == hta_pkg::CMD_GET) begin
            state_d = S_GROW;
          end else begin
            ctrl_o.res = hta_pkg::RES_ZERO;
            state_d    = S_DONE;
          end
        end else begin
          ctrl_o.rd  = hta_pkg::RD_NEXT;
          ctrl_o.idx = hta_pkg::IDX_INC;
        end
      end
      S_GROW: begin
        if (sts_i.grow_ok) begin
          ctrl_o.wr   = hta_pkg::WR_GROW;
          ctrl_o.res  = hta_pkg::RES_GROW;
          ctrl_o.size = hta_pkg::SZ_GROW;
          ctrl_o.idx  = hta_pkg::IDX_GROW;
          state_d     = S_SWEEP;
        end else begin
          ctrl_o.res = hta_pkg::RES_ZERO;
          state_d    = S_DONE;
        end
      end
      S_SWEEP: begin
        // zero the remaining new slots up to the grown size
        ctrl_o.wr = hta_pkg::WR_SWEEP;
        if (sts_i.idx_last) begin
          state_d = S_DONE;
        end else begin
          ctrl_o.idx = hta_pkg::IDX_INC;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_scan_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |->
      ((sts_i.cmd == hta_pkg::CMD_GET) || (sts_i.cmd == hta_pkg::CMD_FIND)))
    else $error("scan running for a command that does not search");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted beat not decoded next cycle");

endmodule

`default_nettype wire

FILE: sv/handle_table_allocator_unit.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  hta_pkg::in_beat_t  (cmd, handle_in, value_in)
// out      output     out_valid_o/out_stall_i hta_pkg::out_beat_t (handle_out, value_out, fault)
//
// One item at a time. Clear, null-value, out-of-range and unused-code items go from accept
// through decode to the result; put/lookup/invalidate add a table read and an execute step.
// Get and find scan live slots one per cycle, with no scan if the table is empty;
// a get that grows adds a grow step and then zeroes the rest of the new slots.
// Reset clears the live size but not the table; new slots are zeroed as the size grows, no clearing pass.
// A waiting result beat in the output register does not block accepting the next item.

module handle_table_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hta_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hta_pkg::out_beat_t      out_beat_o
);

  hta_pkg::ctrl_t ctrl;
  hta_pkg::sts_t  sts;

  hta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  hta_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // command codes the block does not define; they must answer with an all-zero beat
  localparam logic [hta_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [hta_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    hta_pkg::in_beat_t  beat;
    bit                 typed;
    hta_pkg::out_beat_t want;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  hta_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  hta_pkg::out_beat_t out_beat;

  handle_table_allocator_unit #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always #1 clk = ~clk;

  // shadow copy of the handle table
  logic [hta_pkg::VALUE_W-1:0] slots [DEPTH];
  int unsigned                 live_size;
  int unsigned                 peak_size;
  int unsigned                 full_refusals;
  int unsigned                 faults_seen;

  hta_pkg::out_beat_t          pending_results [$];
  stim_row_t                   directed_rows [$];
  logic [hta_pkg::VALUE_W-1:0] value_pool [8];

  int unsigned errors;
  int unsigned sent;
  int unsigned checked;
  int unsigned cycles;
  bit          hold_go;
  bit          hold_done;

  function automatic hta_pkg::out_beat_t apply_command(hta_pkg::in_beat_t b);
    hta_pkg::out_beat_t r;
    int unsigned        n;
    int unsigned        k;
    int unsigned        grown;
    bit                 live;
    r = '0;
    live = (b.handle_in != '0) && (32'(b.handle_in) < live_size);
    case (b.cmd)
      hta_pkg::CMD_CLEAR: begin
        slots = '{default: '0};
        live_size = 0;
      end
      hta_pkg::CMD_GET: begin
        if (b.value_in != '0 && b.value_in != hta_pkg::MARKER) begin
          n = 1;
          while (n < live_size && slots[n[hta_pkg::HANDLE_W-1:0]] != '0) n++;
          if (n < live_size) begin
            slots[n[hta_pkg::HANDLE_W-1:0]] = b.value_in;
            r.handle_out = n[hta_pkg::HANDLE_W-1:0];
          end else begin
            grown = (live_size == 0) ? hta_pkg::FIRST_SIZE : live_size * 2;
            if (grown > DEPTH) begin
              full_refusals++;
            end else begin
              for (k = live_size; k < grown; k++) slots[k[hta_pkg::HANDLE_W-1:0]] = '0;
              live_size = grown;
              if (grown > peak_size) peak_size = grown;
              slots[n[hta_pkg::HANDLE_W-1:0]] = b.value_in;
              r.handle_out = n[hta_pkg::HANDLE_W-1:0];
            end
          end
        end
      end
      hta_pkg::CMD_PUT: begin
        if (live) begin
          r.value_out = slots[b.handle_in];
          slots[b.handle_in] = '0;
        end
      end
      hta_pkg::CMD_LOOKUP: begin
        if (live && slots[b.handle_in] != hta_pkg::MARKER) r.value_out = slots[b.handle_in];
      end
      hta_pkg::CMD_INVAL: begin
        if (live) begin
          r.fault = (slots[b.handle_in] == '0);
          if (r.fault) faults_seen++;
          slots[b.handle_in] = hta_pkg::MARKER;
        end
      end
      hta_pkg::CMD_FIND: begin
        if (b.value_in != '0 && b.value_in != hta_pkg::MARKER) begin
          n = 1;
          while (n < live_size && slots[n[hta_pkg::HANDLE_W-1:0]] != b.value_in) n++;
          if (n < live_size) r.handle_out = n[hta_pkg::HANDLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [hta_pkg::CMD_W-1:0] cmd, int unsigned h,
                                  logic [hta_pkg::VALUE_W-1:0] v, bit typed,
                                  int unsigned hout, logic [hta_pkg::VALUE_W-1:0] vout,
                                  bit fault);
    stim_row_t row;
    row.beat.cmd        = cmd;
    row.beat.handle_in  = h[hta_pkg::HANDLE_W-1:0];
    row.beat.value_in   = v;
    row.typed           = typed;
    row.want.handle_out = hout[hta_pkg::HANDLE_W-1:0];
    row.want.value_out  = vout;
    row.want.fault      = fault;
    directed_rows.push_back(row);
  endfunction

  // fill-heavy mode drives the table to full; mixed mode churns it
  function automatic hta_pkg::in_beat_t random_item(bit fill_mode);
    hta_pkg::in_beat_t b;
    int unsigned       p;
    int unsigned       top;
    p = $urandom_range(0, 99);
    if (fill_mode)
      b.cmd = (p < 80) ? hta_pkg::CMD_GET : (p < 88) ? hta_pkg::CMD_FIND :
              (p < 93) ? hta_pkg::CMD_LOOKUP : (p < 96) ? hta_pkg::CMD_PUT :
              hta_pkg::CMD_INVAL;
    else if (p < 94)
      b.cmd = (p < 28) ? hta_pkg::CMD_GET : (p < 43) ? hta_pkg::CMD_PUT :
              (p < 58) ? hta_pkg::CMD_LOOKUP : (p < 70) ? hta_pkg::CMD_INVAL :
              (p < 90) ? hta_pkg::CMD_FIND : hta_pkg::CMD_CLEAR;
    else
      b.cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
    top = (live_size > 63) ? 63 : live_size;
    b.handle_in = ($urandom_range(0, 3) == 0) ?
                  hta_pkg::HANDLE_W'($urandom_range(0, 63)) :
                  hta_pkg::HANDLE_W'($urandom_range(0, top));
    p = $urandom_range(0, 99);
    if (p < 5)       b.value_in = '0;
    else if (p < 10) b.value_in = hta_pkg::MARKER;
    else if (p < 70) b.value_in = value_pool[3'($urandom_range(0, 7))];
    else             b.value_in = $urandom;
    return b;
  endfunction

  task automatic send_item(input hta_pkg::in_beat_t b, input bit typed,
                           input hta_pkg::out_beat_t want);
    int unsigned        gap;
    hta_pkg::out_beat_t predicted;
    gap = (sent % 64 >= 48) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    predicted = apply_command(b);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("testbench: FAIL");
    $finish;
  end

  // result side: random stall per beat, one long hold to back the block up
  initial begin
    int unsigned        stall_n;
    hta_pkg::out_beat_t want;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stall_n = (checked % 64 >= 40) ? 0 : $urandom_range(0, 11);
        if (stall_n > 0) begin
          out_stall <= 1'b1;
          repeat (stall_n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, out_beat);
      end else begin
        want = pending_results.pop_front();
        if (out_beat.handle_out != want.handle_out) begin
          errors++;
          $display("%0t: handle_out expected %0d got %0d", $time, want.handle_out,
                   out_beat.handle_out);
        end
        if (out_beat.value_out != want.value_out) begin
          errors++;
          $display("%0t: value_out expected %h got %h", $time, want.value_out,
                   out_beat.value_out);
        end
        if (out_beat.fault != want.fault) begin
          errors++;
          $display("%0t: fault expected %0b got %0b", $time, want.fault, out_beat.fault);
        end
      end
    end
  end

  initial begin
    hta_pkg::out_beat_t none;
    int unsigned        i;
    none = '0;
    slots = '{default: '0};
    live_size = 0;
    value_pool[0] = 32'h0000_0001;
    value_pool[1] = 32'hFFFF_FFFE;
    value_pool[2] = 32'h8000_0000;
    for (i = 3; i < 8; i++) value_pool[i[2:0]] = $urandom;

    // empty table, null values, growth, marker handling, reserved codes, clear
    add_row(hta_pkg::CMD_LOOKUP, 1,  32'h0000_1234,   1, 0, '0, 0);
    add_row(hta_pkg::CMD_INVAL,  1,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_GET,    0,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_GET,    63, hta_pkg::MARKER, 1, 0, '0, 0);
    add_row(hta_pkg::CMD_FIND,   0,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_GET,    0,  32'h0000_0001,   1, 1, '0, 0);
    add_row(hta_pkg::CMD_GET,    0,  32'hFFFF_FFFE,   1, 2, '0, 0);
    add_row(hta_pkg::CMD_GET,    0,  32'h8000_0000,   1, 3, '0, 0);
    add_row(hta_pkg::CMD_GET,    0,  32'h0000_0005,   1, 4, '0, 0);
    add_row(hta_pkg::CMD_FIND,   0,  32'hFFFF_FFFE,   1, 2, '0, 0);
    add_row(hta_pkg::CMD_FIND,   0,  hta_pkg::MARKER, 1, 0, '0, 0);
    add_row(hta_pkg::CMD_FIND,   0,  32'h7777_0000,   0, 0, '0, 0);
    add_row(hta_pkg::CMD_LOOKUP, 2,  '0,              1, 0, 32'hFFFF_FFFE, 0);
    add_row(hta_pkg::CMD_INVAL,  5,  '0,              1, 0, '0, 1);
    add_row(hta_pkg::CMD_LOOKUP, 5,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_PUT,    5,  '0,              1, 0, hta_pkg::MARKER, 0);
    add_row(hta_pkg::CMD_PUT,    0,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_PUT,    63, hta_pkg::MARKER, 1, 0, '0, 0);
    add_row(hta_pkg::CMD_INVAL,  1,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_PUT,    1,  '0,              1, 0, hta_pkg::MARKER, 0);
    add_row(hta_pkg::CMD_GET,    0,  32'h0000_0007,   1, 1, '0, 0);
    add_row(hta_pkg::CMD_LOOKUP, 4,  '0,              0, 0, '0, 0);
    add_row(CMD_RSVD_6,          3,  32'h0000_0009,   1, 0, '0, 0);
    add_row(CMD_RSVD_7,          63, hta_pkg::MARKER, 1, 0, '0, 0);
    add_row(hta_pkg::CMD_CLEAR,  0,  '0,              1, 0, '0, 0);
    add_row(hta_pkg::CMD_LOOKUP, 1,  '0,              1, 0, '0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) hold_go = 1'b1;
      if (i == 200)
        send_item('{cmd: hta_pkg::CMD_CLEAR, handle_in: '0, value_in: '0}, 0, none);
      else
        send_item(random_item((i / 100) % 2 == 0), 0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run summary: %0d commands sent, %0d result beats checked, %0d mismatches",
             sent, checked, errors);
    $display("run summary: peak size %0d, %0d gets refused on a full table, %0d faults",
             peak_size, full_refusals, faults_seen);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/hta_pkg.sv
sv/hta_datapath.sv
sv/hta_ctrl.sv
sv/handle_table_allocator_unit.sv
tb/testbench.sv
